>>> rtl/ray_box_slab_test_core_assert.svh
// assertion macros for the ray box slab test block
// expects clk_i and rst_ni in the scope of each use
`ifndef RAY_BOX_SLAB_TEST_CORE_ASSERT_SVH
`define RAY_BOX_SLAB_TEST_CORE_ASSERT_SVH

// same-cycle implication
`define RBST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rbst assertion failed");

// next-cycle implication
`define RBST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rbst assertion failed");

`endif

>>> rtl/rbst_pkg.sv
// shared constants and types for the ray box slab test block
// no dependencies
package rbst_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int NUM_REGS = 6;
  localparam int RIDX_W   = 3;

  localparam logic [RIDX_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [RIDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [RIDX_W-1:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [RIDX_W-1:0] REG_INV_DIR_X = 3'd3;
  localparam logic [RIDX_W-1:0] REG_INV_DIR_Y = 3'd4;
  localparam logic [RIDX_W-1:0] REG_INV_DIR_Z = 3'd5;

  // stage load enables handed to each axis lane
  typedef struct packed {
    logic en_diff;
    logic en_mul;
    logic en_ord;
  } rbst_lane_ctrl_t;

endpackage

>>> rtl/rbst_lane.sv
// one axis lane: bound minus origin, product with inverse direction,
// floor shift with saturation, near/far ordering; uses rbst_pkg
module rbst_lane #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  rbst_pkg::rbst_lane_ctrl_t     ctrl_i,
  input  logic signed [COORD_WIDTH-1:0] origin_i,
  input  logic signed [COORD_WIDTH-1:0] inv_dir_i,
  input  logic signed [COORD_WIDTH-1:0] box_low_i,
  input  logic signed [COORD_WIDTH-1:0] box_high_i,
  output logic signed [COORD_WIDTH-1:0] near_o,
  output logic signed [COORD_WIDTH-1:0] far_o
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * COORD_WIDTH + 1;

  logic signed [DW-1:0] d_lo_q, d_hi_q, d_lo_d, d_hi_d;
  logic signed [PW-1:0] p_lo_q, p_hi_q, p_lo_d, p_hi_d;
  logic signed [COORD_WIDTH-1:0] t_lo, t_hi, near_q, far_q;

  // clamp a shifted product into the coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [PW-1:0] v
  );
    logic [COORD_WIDTH+1:0] top;
    logic pos_ovf;
    logic neg_ovf;
    top     = v[PW-1:COORD_WIDTH-1];
    pos_ovf = !v[PW-1] && (|top);
    neg_ovf = v[PW-1] && !(&top);
    if (pos_ovf) begin
      sat_coord = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end else if (neg_ovf) begin
      sat_coord = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      sat_coord = v[COORD_WIDTH-1:0];
    end
  endfunction

  assign d_lo_d = $signed({box_low_i[COORD_WIDTH-1], box_low_i})
                - $signed({origin_i[COORD_WIDTH-1], origin_i});
  assign d_hi_d = $signed({box_high_i[COORD_WIDTH-1], box_high_i})
                - $signed({origin_i[COORD_WIDTH-1], origin_i});

  assign p_lo_d = PW'(d_lo_q) * PW'(inv_dir_i);
  assign p_hi_d = PW'(d_hi_q) * PW'(inv_dir_i);

  // arithmetic shift rounds toward minus infinity
  assign t_lo = sat_coord(p_lo_q >>> FRAC_BITS);
  assign t_hi = sat_coord(p_hi_q >>> FRAC_BITS);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_diff) begin
      d_lo_q <= d_lo_d;
      d_hi_q <= d_hi_d;
    end
    if (ctrl_i.en_mul) begin
      p_lo_q <= p_lo_d;
      p_hi_q <= p_hi_d;
    end
    if (ctrl_i.en_ord) begin
      near_q <= (t_lo < t_hi) ? t_lo : t_hi;
      far_q  <= (t_lo > t_hi) ? t_lo : t_hi;
    end
  end

  assign near_o = near_q;
  assign far_o  = far_q;

endmodule

>>> rtl/rbst_merge.sv
// merge stage: latest entry and earliest exit over the three lanes,
// clipped to the ray interval, registered hit flag; uses rbst_pkg widths
module rbst_merge #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [COORD_WIDTH-1:0] near_i [3],
  input  logic signed [COORD_WIDTH-1:0] far_i  [3],
  input  logic signed [COORD_WIDTH-1:0] t_low_i,
  input  logic signed [COORD_WIDTH-1:0] t_high_i,
  output logic                          hit_o
);

  logic signed [COORD_WIDTH-1:0] ent_a, ent_b, ent_m;
  logic signed [COORD_WIDTH-1:0] ext_a, ext_b, ext_m;
  logic hit_q;

  // two-level max and min trees
  assign ent_a = (near_i[0] > t_low_i)   ? near_i[0] : t_low_i;
  assign ent_b = (near_i[2] > near_i[1]) ? near_i[2] : near_i[1];
  assign ent_m = (ent_b > ent_a)         ? ent_b     : ent_a;

  assign ext_a = (far_i[0] < t_high_i)   ? far_i[0]  : t_high_i;
  assign ext_b = (far_i[2] < far_i[1])   ? far_i[2]  : far_i[1];
  assign ext_m = (ext_b < ext_a)         ? ext_b     : ext_a;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q <= (ent_m <= ext_m);
    end
  end

  assign hit_o = hit_q;

endmodule

>>> rtl/ray_box_slab_test_core.sv
// top level of the ray box slab test: apb register file, three axis lanes,
// merge stage and pipeline control; uses rbst_pkg, rbst_lane, rbst_merge
//
// usage: write the ray origin (registers 0..2) and inverse direction
// (registers 3..5), Q16.16 by default, through the apb port while no
// transaction is in flight; pready is always high and reads return the
// register. then stream boxes on the input channel, one per transaction,
// each with its own ray interval; every box yields one hit transaction
// on the output channel, in order.
// stages: difference, multiply, order, merge; out_valid_o marks the last.
// throughput: one box per cycle while in_stall_o is low; each stage
// holds one transaction and the three axis lanes run side by side, with
// one multiplier per crossing.
// stall: out_stall_i holds the output register; earlier stages keep
// filling bubbles, and in_stall_o rises only once all four stages hold
// a transaction.
// reset: rst_ni clears all stage valid bits, sets origin to zero and the
// inverse direction to one.
module ray_box_slab_test_core #(
  parameter int COORD_WIDTH = rbst_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = rbst_pkg::FRAC_BITS_DEF,
  parameter int DATA_W      = (COORD_WIDTH > 32) ? 64 : 32,
  parameter int ADDR_LSB    = (COORD_WIDTH > 32) ? 3 : 2,
  parameter int ADDR_W      = rbst_pkg::RIDX_W + ADDR_LSB
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [DATA_W-1:0]             pwdata,
  output logic [DATA_W-1:0]             prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [COORD_WIDTH-1:0] box_x_low_i,
  input  logic signed [COORD_WIDTH-1:0] box_x_high_i,
  input  logic signed [COORD_WIDTH-1:0] box_y_low_i,
  input  logic signed [COORD_WIDTH-1:0] box_y_high_i,
  input  logic signed [COORD_WIDTH-1:0] box_z_low_i,
  input  logic signed [COORD_WIDTH-1:0] box_z_high_i,
  input  logic signed [COORD_WIDTH-1:0] ray_t_low_i,
  input  logic signed [COORD_WIDTH-1:0] ray_t_high_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          hit_o
);

  localparam logic [COORD_WIDTH-1:0] ONE_FIX =
    {{(COORD_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

  logic signed [COORD_WIDTH-1:0] origin_q [3];
  logic signed [COORD_WIDTH-1:0] inv_q    [3];
  logic [rbst_pkg::RIDX_W-1:0] reg_idx;
  logic cfg_wr;

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic signed [COORD_WIDTH-1:0] tl1_q, tl2_q, tl3_q, th1_q, th2_q, th3_q;
  rbst_pkg::rbst_lane_ctrl_t lane_ctrl;
  logic signed [COORD_WIDTH-1:0] box_low  [3];
  logic signed [COORD_WIDTH-1:0] box_high [3];
  logic signed [COORD_WIDTH-1:0] near     [3];
  logic signed [COORD_WIDTH-1:0] far      [3];

  // configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:ADDR_LSB];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        inv_q[i]    <= ONE_FIX;
      end
    end else if (cfg_wr) begin
      case (reg_idx)
        rbst_pkg::REG_ORIGIN_X:  origin_q[0] <= pwdata[COORD_WIDTH-1:0];
        rbst_pkg::REG_ORIGIN_Y:  origin_q[1] <= pwdata[COORD_WIDTH-1:0];
        rbst_pkg::REG_ORIGIN_Z:  origin_q[2] <= pwdata[COORD_WIDTH-1:0];
        rbst_pkg::REG_INV_DIR_X: inv_q[0]    <= pwdata[COORD_WIDTH-1:0];
        rbst_pkg::REG_INV_DIR_Y: inv_q[1]    <= pwdata[COORD_WIDTH-1:0];
        rbst_pkg::REG_INV_DIR_Z: inv_q[2]    <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rbst_pkg::REG_ORIGIN_X:  prdata = DATA_W'(unsigned'(origin_q[0]));
      rbst_pkg::REG_ORIGIN_Y:  prdata = DATA_W'(unsigned'(origin_q[1]));
      rbst_pkg::REG_ORIGIN_Z:  prdata = DATA_W'(unsigned'(origin_q[2]));
      rbst_pkg::REG_INV_DIR_X: prdata = DATA_W'(unsigned'(inv_q[0]));
      rbst_pkg::REG_INV_DIR_Y: prdata = DATA_W'(unsigned'(inv_q[1]));
      rbst_pkg::REG_INV_DIR_Z: prdata = DATA_W'(unsigned'(inv_q[2]));
      default:                 prdata = '0;
    endcase
  end

  // per-stage ready lets bubbles collapse under output stall
  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_stall_o = !rdy1;
  assign out_valid_o = v4_q;

  assign lane_ctrl.en_diff = rdy1 && in_valid_i;
  assign lane_ctrl.en_mul  = rdy2 && v1_q;
  assign lane_ctrl.en_ord  = rdy3 && v2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // ray interval travels alongside the lanes
  always_ff @(posedge clk_i) begin
    if (lane_ctrl.en_diff) begin
      tl1_q <= ray_t_low_i;
      th1_q <= ray_t_high_i;
    end
    if (lane_ctrl.en_mul) begin
      tl2_q <= tl1_q;
      th2_q <= th1_q;
    end
    if (lane_ctrl.en_ord) begin
      tl3_q <= tl2_q;
      th3_q <= th2_q;
    end
  end

  assign box_low[0]  = box_x_low_i;
  assign box_high[0] = box_x_high_i;
  assign box_low[1]  = box_y_low_i;
  assign box_high[1] = box_y_high_i;
  assign box_low[2]  = box_z_low_i;
  assign box_high[2] = box_z_high_i;

  for (genvar a = 0; a < 3; a++) begin : g_lane
    rbst_lane #(
      .COORD_WIDTH (COORD_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (lane_ctrl),
      .origin_i   (origin_q[a]),
      .inv_dir_i  (inv_q[a]),
      .box_low_i  (box_low[a]),
      .box_high_i (box_high[a]),
      .near_o     (near[a]),
      .far_o      (far[a])
    );
  end

  rbst_merge #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_merge (
    .clk_i    (clk_i),
    .en_i     (rdy4 && v3_q),
    .near_i   (near),
    .far_i    (far),
    .t_low_i  (tl3_q),
    .t_high_i (th3_q),
    .hit_o    (hit_o)
  );

`include "ray_box_slab_test_core_assert.svh"

  `RBST_ASSERT_NEXT(a_accept_fills_s1, in_valid_i && !in_stall_o, v1_q)
  `RBST_ASSERT_NOW(a_stall_only_full, in_stall_o, v1_q && v2_q && v3_q && v4_q && out_stall_i)
  `RBST_ASSERT_NOW(a_out_from_s3, $rose(out_valid_o), $past(v3_q))

endmodule

>>> tb/tb_ray_box_slab_test_core.sv
// self-checking testbench for ray_box_slab_test_core: slab hit test on random and directed boxes
// depends on rbst_pkg and the rtl of ray_box_slab_test_core; needs no other files
module tb_ray_box_slab_test_core;

  localparam int FRAC        = rbst_pkg::FRAC_BITS_DEF;
  localparam int RIDX_W      = rbst_pkg::RIDX_W;
  localparam int NUM_REGS    = rbst_pkg::NUM_REGS;
  localparam int ADDR_BITS   = RIDX_W + 2;
  localparam int N_DIR       = 19;
  localparam int N_PHASES    = 9;
  localparam int RAND_ITEMS  = 90;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [RIDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [RIDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [31:0] Q_ZERO = 32'h0000_0000;
  localparam logic [31:0] Q_LSB  = 32'h0000_0001;
  localparam logic [31:0] Q_ONE  = 32'h0001_0000;
  localparam logic [31:0] Q_TWO  = 32'h0002_0000;
  localparam logic [31:0] Q_TRI  = 32'h0003_0000;
  localparam logic [31:0] Q_NLSB = 32'hffff_ffff;
  localparam logic [31:0] Q_NONE = 32'hffff_0000;
  localparam logic [31:0] Q_NTWO = 32'hfffe_0000;
  localparam logic [31:0] Q_NTRI = 32'hfffd_0000;
  localparam logic [31:0] Q_MAX  = 32'h7fff_ffff;
  localparam logic [31:0] Q_MIN  = 32'h8000_0000;
  localparam logic [31:0] Q_ALT0 = 32'h5555_5555;
  localparam logic [31:0] Q_ALT1 = 32'haaaa_aaaa;

  localparam logic signed [64:0] T_SAT_HI = 65'sd2147483647;
  localparam logic signed [64:0] T_SAT_LO = -65'sd2147483648;

  typedef enum logic [1:0] {EXP_MISS, EXP_HIT, EXP_PREDICT} dir_exp_e;

  typedef struct {
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
    logic signed [31:0] t_low;
    logic signed [31:0] t_high;
  } slab_box_t;

  typedef struct {
    bit hit;
    int tag;
  } hit_exp_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_BITS-1:0]  paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic signed [31:0]    box_x_low_i;
  logic signed [31:0]    box_x_high_i;
  logic signed [31:0]    box_y_low_i;
  logic signed [31:0]    box_y_high_i;
  logic signed [31:0]    box_z_low_i;
  logic signed [31:0]    box_z_high_i;
  logic signed [31:0]    ray_t_low_i;
  logic signed [31:0]    ray_t_high_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  hit_o;

  // ray state as the block should hold it
  logic signed [31:0] ray_org [3];
  logic signed [31:0] ray_inv [3];

  hit_exp_t pending_hits [$];
  hit_exp_t hit_head;
  int       mismatch_cnt;
  int       box_cnt;
  bit       quiet_q;

  // box x lo/hi, y lo/hi, z lo/hi, t lo/hi, expected under the reset ray
  logic [31:0] dir_rows [0:N_DIR-1][0:8] = '{
    '{Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  EXP_HIT},
    '{Q_TWO,  Q_TRI,  Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  EXP_MISS},
    '{Q_ONE,  Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  Q_ZERO, Q_ZERO, Q_ONE,  EXP_HIT},
    '{Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  Q_ONE,  Q_ZERO, EXP_MISS},
    '{Q_ONE,  Q_TWO,  Q_ONE,  Q_TWO,  Q_ONE,  Q_TWO,  Q_ZERO, Q_ONE,  EXP_HIT},
    '{Q_MIN,  Q_MAX,  Q_MIN,  Q_MAX,  Q_MIN,  Q_MAX,  Q_MIN,  Q_MAX,  EXP_HIT},
    '{Q_MIN,  Q_MIN,  Q_MIN,  Q_MIN,  Q_MIN,  Q_MIN,  Q_MIN,  Q_MIN,  EXP_HIT},
    '{Q_MAX,  Q_MAX,  Q_MAX,  Q_MAX,  Q_MAX,  Q_MAX,  Q_MAX,  Q_MAX,  EXP_HIT},
    '{Q_MAX,  Q_MIN,  Q_MAX,  Q_MIN,  Q_MAX,  Q_MIN,  Q_ZERO, Q_ZERO, EXP_HIT},
    '{Q_MIN,  Q_MAX,  Q_MIN,  Q_MAX,  Q_MIN,  Q_MAX,  Q_MAX,  Q_MIN,  EXP_MISS},
    '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, EXP_HIT},
    '{Q_NTWO, Q_NONE, Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  Q_ZERO, Q_MAX,  EXP_MISS},
    '{Q_NONE, Q_ONE,  Q_NONE, Q_ONE,  Q_NONE, Q_ONE,  Q_MIN,  Q_MAX,  EXP_HIT},
    '{Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_NLSB, Q_ZERO, EXP_HIT},
    '{Q_ZERO, Q_ONE,  Q_TRI,  Q_TWO,  Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  EXP_MISS},
    '{Q_ZERO, Q_ONE,  Q_ZERO, Q_ONE,  Q_NTRI, Q_NTWO, Q_MIN,  Q_MAX,  EXP_MISS},
    '{Q_ALT0, Q_ALT1, Q_ALT0, Q_ALT1, Q_ALT0, Q_ALT1, Q_ALT1, Q_ALT0, EXP_PREDICT},
    '{Q_ALT1, Q_ALT0, Q_ALT1, Q_ALT0, Q_ALT1, Q_ALT0, Q_ALT0, Q_ALT1, EXP_PREDICT},
    '{Q_LSB,  Q_NLSB, Q_LSB,  Q_NLSB, Q_LSB,  Q_NLSB, Q_NLSB, Q_LSB,  EXP_PREDICT}
  };

  ray_box_slab_test_core dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_cnt < 40) $display("MISMATCH: %s", msg);
    mismatch_cnt++;
  endtask

  // crossing parameter: exact product, floor shift, saturate to 32 bits
  function automatic logic signed [31:0] slab_cross(input logic signed [31:0] bound,
                                                    input logic signed [31:0] org,
                                                    input logic signed [31:0] inv);
    logic signed [64:0] span;
    logic signed [64:0] prod;
    logic signed [64:0] q;
    span = bound;
    span = span - org;
    prod = span * inv;
    q = prod >>> FRAC;
    if (q > T_SAT_HI) return Q_MAX;
    if (q < T_SAT_LO) return Q_MIN;
    return q[31:0];
  endfunction

  function automatic bit box_is_hit(input slab_box_t b);
    logic signed [31:0] enter;
    logic signed [31:0] leave;
    logic signed [31:0] ta;
    logic signed [31:0] tz;
    enter = b.t_low;
    leave = b.t_high;
    for (int a = 0; a < 3; a++) begin
      ta = slab_cross(b.lo[a], ray_org[a], ray_inv[a]);
      tz = slab_cross(b.hi[a], ray_org[a], ray_inv[a]);
      if (ta > tz) begin
        ta = tz;
        tz = slab_cross(b.lo[a], ray_org[a], ray_inv[a]);
      end
      if (ta > enter) enter = ta;
      if (tz < leave) leave = tz;
    end
    return enter <= leave;
  endfunction

  function automatic logic [31:0] reg_model(input logic [RIDX_W-1:0] idx);
    case (idx)
      rbst_pkg::REG_ORIGIN_X:  return ray_org[0];
      rbst_pkg::REG_ORIGIN_Y:  return ray_org[1];
      rbst_pkg::REG_ORIGIN_Z:  return ray_org[2];
      rbst_pkg::REG_INV_DIR_X: return ray_inv[0];
      rbst_pkg::REG_INV_DIR_Y: return ray_inv[1];
      rbst_pkg::REG_INV_DIR_Z: return ray_inv[2];
      default:                 return '0;
    endcase
  endfunction

  // signed value of up to s magnitude bits
  function automatic logic signed [31:0] rnd_span(input int s);
    logic signed [31:0] v;
    v = $urandom >> (32 - s);
    if ($urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  task automatic reg_read(input logic [RIDX_W-1:0] idx, output logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    val = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input logic [RIDX_W-1:0] idx, input logic [31:0] data);
    logic [31:0] rd;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      rbst_pkg::REG_ORIGIN_X:  ray_org[0] = data;
      rbst_pkg::REG_ORIGIN_Y:  ray_org[1] = data;
      rbst_pkg::REG_ORIGIN_Z:  ray_org[2] = data;
      rbst_pkg::REG_INV_DIR_X: ray_inv[0] = data;
      rbst_pkg::REG_INV_DIR_Y: ray_inv[1] = data;
      rbst_pkg::REG_INV_DIR_Z: ray_inv[2] = data;
      default: ;
    endcase
    if (idx < NUM_REGS) begin
      reg_read(idx, rd);
      if (rd !== data)
        report_mismatch($sformatf("reg %0d reads %h, wrote %h", idx, rd, data));
    end
  endtask

  task automatic load_ray(input logic [31:0] o [3], input logic [31:0] v [3]);
    reg_write(rbst_pkg::REG_ORIGIN_X, o[0]);
    reg_write(rbst_pkg::REG_ORIGIN_Y, o[1]);
    reg_write(rbst_pkg::REG_ORIGIN_Z, o[2]);
    reg_write(rbst_pkg::REG_INV_DIR_X, v[0]);
    reg_write(rbst_pkg::REG_INV_DIR_Y, v[1]);
    reg_write(rbst_pkg::REG_INV_DIR_Z, v[2]);
  endtask

  task automatic send_box(input slab_box_t b, input bit want);
    int gap;
    hit_exp_t e;
    gap = (!quiet_q && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    box_x_low_i  <= b.lo[0];
    box_x_high_i <= b.hi[0];
    box_y_low_i  <= b.lo[1];
    box_y_high_i <= b.hi[1];
    box_z_low_i  <= b.lo[2];
    box_z_high_i <= b.hi[2];
    ray_t_low_i  <= b.t_low;
    ray_t_high_i <= b.t_high;
    do @(posedge clk_i); while (in_stall_o);
    e.hit = want;
    e.tag = box_cnt;
    pending_hits.push_back(e);
    box_cnt++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // mostly boxes scattered around the ray origin, some fully random
  function automatic slab_box_t gen_box();
    slab_box_t b;
    logic signed [31:0] c;
    int s;
    if ($urandom_range(0, 4) == 0) begin
      for (int a = 0; a < 3; a++) begin
        b.lo[a] = $urandom;
        b.hi[a] = $urandom;
      end
      b.t_low  = $urandom;
      b.t_high = $urandom;
    end else begin
      for (int a = 0; a < 3; a++) begin
        s = $urandom_range(8, 26);
        c = ray_org[a] + rnd_span($urandom_range(4, 28));
        b.lo[a] = c + rnd_span(s);
        b.hi[a] = c + rnd_span(s);
      end
      b.t_low  = ($urandom_range(0, 3) == 0) ? rnd_span($urandom_range(1, 31)) : Q_ZERO;
      b.t_high = ($urandom_range(0, 2) == 0) ? rnd_span($urandom_range(1, 31)) : Q_MAX;
    end
    return b;
  endfunction

  // output side back-pressure in bursts
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
      repeat (n) begin
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      if (!quiet_q) begin
        n = $urandom_range(1, 17);
        repeat (n) begin
          @(negedge clk_i);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_hits.size() == 0) begin
        report_mismatch($sformatf("hit transaction with nothing pending, hit=%b", hit_o));
      end else begin
        hit_head = pending_hits.pop_front();
        if (hit_o !== hit_head.hit)
          report_mismatch($sformatf("box %0d: hit=%b, predicted %b",
                                    hit_head.tag, hit_o, hit_head.hit));
      end
    end
  end

  initial begin
    slab_box_t b;
    logic [31:0] cfg_o [3];
    logic [31:0] cfg_v [3];
    logic [31:0] rd;
    bit want;

    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    in_valid_i   = 1'b0;
    box_x_low_i  = '0;
    box_x_high_i = '0;
    box_y_low_i  = '0;
    box_y_high_i = '0;
    box_z_low_i  = '0;
    box_z_high_i = '0;
    ray_t_low_i  = '0;
    ray_t_high_i = '0;
    quiet_q      = 1'b0;
    mismatch_cnt = 0;
    box_cnt      = 0;
    for (int a = 0; a < 3; a++) begin
      ray_org[a] = Q_ZERO;
      ray_inv[a] = Q_ONE;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NUM_REGS; r++) begin
      reg_read(r[RIDX_W-1:0], rd);
      if (rd !== reg_model(r[RIDX_W-1:0]))
        report_mismatch($sformatf("reg %0d after reset reads %h", r, rd));
    end

    for (int p = 0; p < N_PHASES; p++) begin
      // ray setup per phase: reset ray, zero and saturated slopes, then random rays
      case (p)
        0: ;
        1: begin
          cfg_o = '{Q_ZERO, Q_ZERO, Q_ZERO};
          cfg_v = '{Q_ZERO, Q_ONE, Q_ONE};
        end
        2: begin
          cfg_o = '{Q_MAX, Q_MIN, Q_ZERO};
          cfg_v = '{Q_MAX, Q_MIN, Q_ONE};
        end
        3: begin
          cfg_o = '{Q_MIN, Q_MAX, Q_ONE};
          cfg_v = '{Q_MIN, Q_MAX, Q_ZERO};
        end
        default: begin
          for (int a = 0; a < 3; a++) begin
            cfg_o[a] = rnd_span($urandom_range(4, 31));
            case ($urandom_range(0, 7))
              0:       cfg_v[a] = $urandom;
              1:       cfg_v[a] = Q_ZERO;
              2:       cfg_v[a] = Q_MAX;
              3:       cfg_v[a] = Q_MIN;
              default: cfg_v[a] = rnd_span($urandom_range(8, 24));
            endcase
          end
        end
      endcase
      if (p > 0) load_ray(cfg_o, cfg_v);
      if (p == 1) begin
        // writes past the last register must leave the ray untouched
        reg_write(REG_SPARE_LO, $urandom);
        reg_write(REG_SPARE_HI, $urandom);
      end
      quiet_q = (p == N_PHASES - 1);

      for (int i = 0; i < N_DIR; i++) begin
        for (int a = 0; a < 3; a++) begin
          b.lo[a] = dir_rows[i][2 * a];
          b.hi[a] = dir_rows[i][2 * a + 1];
        end
        b.t_low  = dir_rows[i][6];
        b.t_high = dir_rows[i][7];
        if (p == 0 && dir_rows[i][8] != EXP_PREDICT) want = (dir_rows[i][8] == EXP_HIT);
        else want = box_is_hit(b);
        send_box(b, want);
      end

      for (int i = 0; i < RAND_ITEMS; i++) begin
        b = gen_box();
        send_box(b, box_is_hit(b));
      end
      drain_results();
    end

    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
